### rtl/rsmp_pkg.sv
// Shared types and constants for the linear interpolation stereo resampler.
// No dependencies.
package rsmp_pkg;

	localparam int SMP_W      = 16;  // source PCM sample width
	localparam int RES_W      = 20;  // result sample width
	localparam int STEP_W     = 23;  // phase increment width
	localparam int CNT_W      = 28;  // source / result counters
	localparam int PHASE_W    = 44;  // phase accumulator
	localparam int MAX_RUN    = 64;  // results per item, upper bound
	localparam int RUN_W      = 7;   // holds 0..MAX_RUN
	localparam int QDEPTH     = 4;   // front-to-back queue depth
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 28;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO      = 2'd2;

	typedef struct packed {
		logic signed [SMP_W-1:0] in_left;
		logic signed [SMP_W-1:0] in_right;
		logic                    in_last;
	} smp_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] out_left;
		logic signed [RES_W-1:0] out_right;
		logic                    run_last;
		logic                    done_res;
	} res_item_t;

	// item as classified by the front end
	typedef struct packed {
		smp_item_t data;
		logic      first;   // opens a new stream
	} q_item_t;

	// one interpolation job handed to the blend pipeline
	typedef struct packed {
		logic signed [SMP_W-1:0] a_left;
		logic signed [SMP_W-1:0] a_right;
		logic signed [SMP_W-1:0] b_left;
		logic signed [SMP_W-1:0] b_right;
		logic                    done;
		logic                    last;
	} blend_pair_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_LOOP,
		SEQ_TAIL,
		SEQ_FINISH
	} seq_state_t;

endpackage

### rtl/rsmp_front.sv
// Front end: accepts sample items, tags stream starts, queues them for the back end.
// Depends on rsmp_pkg.
module rsmp_front import rsmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      smp_valid,
	output logic      smp_stall,
	input  smp_item_t smp_item,
	output logic      q_valid,
	input  logic      q_pop,
	output q_item_t   q_item
);

	q_item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                start_q;   // next item opens a stream
	logic                push;
	logic                pop;

	assign smp_stall = (count_q == QCNT_W'(QDEPTH));
	assign push      = smp_valid && !smp_stall;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: smp_item, first: start_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			start_q  <= 1'b1;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				start_q  <= smp_item.in_last;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/rsmp_blend.sv
// Blend pipeline: a + ((b - a) * f >>> FRAC_BITS), times ten, per channel; output register.
// In mono mode both outputs carry the left result. Depends on rsmp_pkg.
module rsmp_blend import rsmp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  blend_pair_t          pair,
	input  logic [FRAC_BITS-1:0] frac,
	input  logic                 mono,
	output logic                 en,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_item_t            res_item
);

	localparam int DIFF_W = SMP_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int SH_W   = DIFF_W + 1;

	logic                     v_s1, v_s2, v_q;
	logic signed [DIFF_W-1:0] dl_s1, dr_s1;
	logic signed [SMP_W-1:0]  al_s1, ar_s1, al_s2, ar_s2;
	logic [FRAC_BITS-1:0]     f_s1;
	logic                     done_s1, last_s1, done_s2, last_s2;
	logic signed [PROD_W-1:0] pl_s2, pr_s2;
	logic signed [PROD_W-1:0] shl, shr;
	logic signed [RES_W-1:0]  ql, qr, tl, tr;
	res_item_t                res_q;

	// whole pipeline moves unless the output is held
	assign en        = !(v_q && res_stall);
	assign res_valid = v_q;
	assign res_item  = res_q;

	assign shl = pl_s2 >>> FRAC_BITS;
	assign shr = pr_s2 >>> FRAC_BITS;
	assign ql  = RES_W'(al_s2) + RES_W'($signed(shl[SH_W-1:0]));
	assign qr  = RES_W'(ar_s2) + RES_W'($signed(shr[SH_W-1:0]));
	assign tl  = (ql <<< 3) + (ql <<< 1);
	assign tr  = (qr <<< 3) + (qr <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s1   <= DIFF_W'(pair.b_left) - DIFF_W'(pair.a_left);
			dr_s1   <= DIFF_W'(pair.b_right) - DIFF_W'(pair.a_right);
			al_s1   <= pair.a_left;
			ar_s1   <= pair.a_right;
			f_s1    <= frac;
			done_s1 <= pair.done;
			last_s1 <= pair.last;

			pl_s2   <= dl_s1 * $signed({1'b0, f_s1});
			pr_s2   <= dr_s1 * $signed({1'b0, f_s1});
			al_s2   <= al_s1;
			ar_s2   <= ar_s1;
			done_s2 <= done_s1;
			last_s2 <= last_s1;

			res_q.out_left  <= tl;
			res_q.out_right <= mono ? tl : tr;
			res_q.run_last  <= last_s2;
			res_q.done_res  <= done_s2;
		end
	end

endmodule

### rtl/rsmp_seq.sv
// Back end sequencer: walks one queued item through its interpolation and tail runs,
// keeps stream state, issues blend jobs. Depends on rsmp_pkg.
module rsmp_seq import rsmp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  q_item_t              q_item,
	input  logic [STEP_W-1:0]    step,
	input  logic [CNT_W-1:0]     out_count,
	input  logic                 en,
	output logic                 push,
	output blend_pair_t          pair,
	output logic [FRAC_BITS-1:0] frac
);

	localparam int INT_W = PHASE_W - FRAC_BITS;
	localparam int CMP_W = (INT_W > CNT_W) ? INT_W : CNT_W;

	seq_state_t              state_q, state_d;
	q_item_t                 cur_q;
	logic signed [SMP_W-1:0] prev_l_q, prev_r_q, first_l_q, first_r_q;
	logic [CNT_W-1:0]        src_idx_q, dst_idx_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [RUN_W-1:0]        n_q;
	blend_pair_t             pend_q;
	logic [FRAC_BITS-1:0]    pend_f_q;
	logic                    pend_v_q;

	logic                    room, owed, ahead, loop_go, tail_go;
	logic                    emit, flush;
	blend_pair_t             job;

	assign room    = n_q < RUN_W'(MAX_RUN);
	assign owed    = dst_idx_q < out_count;
	assign ahead   = CMP_W'(phase_q[PHASE_W-1:FRAC_BITS]) < CMP_W'(src_idx_q);
	assign loop_go = !cur_q.first && room && owed && ahead;
	assign tail_go = room && owed;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (q_valid) state_d = SEQ_LOOP;
			end
			SEQ_LOOP: begin
				if (!loop_go) state_d = cur_q.data.in_last ? SEQ_TAIL : SEQ_FINISH;
			end
			SEQ_TAIL: begin
				if (!tail_go) state_d = SEQ_FINISH;
			end
			SEQ_FINISH: begin
				if (en) state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		flush = 1'b0;
		job   = '0;
		case (state_q)
			SEQ_IDLE: begin
				q_pop = q_valid;
			end
			SEQ_LOOP: begin
				emit = en && loop_go;
				job  = '{a_left: prev_l_q, a_right: prev_r_q,
				         b_left: cur_q.data.in_left, b_right: cur_q.data.in_right,
				         done: 1'b0, last: 1'b0};
			end
			SEQ_TAIL: begin
				emit = en && tail_go;
				job  = '{a_left: cur_q.data.in_left, a_right: cur_q.data.in_right,
				         b_left: first_l_q, b_right: first_r_q,
				         done: 1'b0, last: 1'b0};
			end
			SEQ_FINISH: begin
				flush = en;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		job.done = (dst_idx_q == out_count - 1'b1);
		// the held job goes out once we know whether another follows
		push      = (emit || flush) && pend_v_q;
		pair      = pend_q;
		pair.last = flush;
		frac      = pend_f_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			src_idx_q <= '0;
			dst_idx_q <= '0;
			phase_q   <= '0;
			n_q       <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				n_q <= '0;
			end
			if (emit) begin
				pend_v_q  <= 1'b1;
				dst_idx_q <= dst_idx_q + 1'b1;
				phase_q   <= phase_q + PHASE_W'(step);
				n_q       <= n_q + 1'b1;
			end
			if (flush) begin
				pend_v_q <= 1'b0;
				if (cur_q.data.in_last) begin
					src_idx_q <= '0;
					dst_idx_q <= '0;
					phase_q   <= '0;
				end else begin
					src_idx_q <= src_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
			if (q_item.first) begin
				first_l_q <= q_item.data.in_left;
				first_r_q <= q_item.data.in_right;
			end
		end
		if (emit) begin
			pend_q   <= job;
			pend_f_q <= phase_q[FRAC_BITS-1:0];
		end
		if (flush && !cur_q.data.in_last) begin
			prev_l_q <= cur_q.data.in_left;
			prev_r_q <= cur_q.data.in_right;
		end
	end

endmodule

### rtl/linear_interp_stereo_resampler.sv
// Top level of the linear interpolation stereo resampler.
// Depends on rsmp_pkg, rsmp_front, rsmp_seq, rsmp_blend.
//
// Usage
//   smp channel: one stereo PCM source sample per item (valid/stall). in_last closes
//     a stream; the next item opens a new one at position zero.
//   res channel: interpolated results (valid/stall). Result n sits at source position
//     n*step; each item releases the results whose upper sample it supplies, and the
//     last item of a stream also releases the remaining results up to out_count,
//     pairing the final sample with the first. run_last flags the final result of
//     an item, done_res flags result number out_count-1. At most 64 per item.
//   cfg channel: valid/ready writes of step, out_count, mono; ready is always high.
//     Write only while the block is idle.
// Timing
//   A four-entry queue takes items while the back end works. The sequencer fetches an
//   item in its idle state, issues results (loop, then tail for the last item of a
//   stream) and closes the item in its finish state. The blend pipeline registers each
//   job through its difference, product and output registers. Results stream at one per
//   cycle within an item while res_stall is low.
// Reset clears queue, stream counters and output valid. A stalled result holds the
//   output register, freezes the blend pipeline and stops the sequencer issuing results;
//   the queue keeps taking items until it is full.
module linear_interp_stereo_resampler import rsmp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  smp_valid,
	output logic                  smp_stall,
	input  smp_item_t             smp_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_item_t             res_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 mono_q;

	logic                 q_valid, q_pop;
	q_item_t              q_item;
	logic                 en, push;
	blend_pair_t          pair;
	logic [FRAC_BITS-1:0] frac;

	// config registers; the user writes them between streams, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RESET;
			out_count_q <= '0;
			mono_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
				CFG_OUT_COUNT: out_count_q <= cfg_data[CNT_W-1:0];
				CFG_MONO:      mono_q      <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// front: accept and tag stream starts
	rsmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_item  (smp_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	// back: per-item result runs
	rsmp_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.step      (step_q),
		.out_count (out_count_q),
		.en        (en),
		.push      (push),
		.pair      (pair),
		.frac      (frac)
	);

	// back: arithmetic and output register
	rsmp_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pair      (pair),
		.frac      (frac),
		.mono      (mono_q),
		.en        (en),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

### rtl/rsmp_check.sv
// Port-level checks for the resampler, bound to the top level.
// Depends on rsmp_pkg and linear_interp_stereo_resampler.
module rsmp_check import rsmp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  smp_valid,
	input logic                  smp_stall,
	input smp_item_t             smp_item,
	input logic                  res_valid,
	input logic                  res_stall,
	input res_item_t             res_item,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic signed [RES_W-1:0] RES_MIN = -20'sd327680;
	localparam logic signed [RES_W-1:0] RES_MAX = 20'sd327670;

	logic seen_q;   // some item accepted since reset

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (smp_valid && !smp_stall) begin
			seen_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> seen_q)
		else $error("result before any item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.out_left >= RES_MIN && res_item.out_left <= RES_MAX &&
		              res_item.out_right >= RES_MIN && res_item.out_right <= RES_MAX)
		else $error("result out of range");

endmodule

bind linear_interp_stereo_resampler rsmp_check u_rsmp_check (.*);
